>>> hw/rtl/fbl_pkg.sv
// Shared types and constants for the first-fit free block list.
// No dependencies; imported by fbl_ctrl, fbl_dpath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fbl_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int ADDR_BITS  = 48;
  localparam int SIZE_BITS  = 32;
  localparam int TOTAL_W    = 38;
  localparam int FUNC_W     = 3;

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_FREE  = 3'd0,
    FN_OBT_S = 3'd1,
    FN_OBT_L = 3'd2,
    FN_LKP_S = 3'd3,
    FN_LKP_L = 3'd4,
    FN_REBLD = 3'd5
  } func_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_BITS-1:0] size;
  } entry_t;

  typedef struct packed {
    logic load;
    logic push;
    logic clear;
    logic scan_start;
    logic scan_single;
    logic scan_step;
    logic shift_start;
    logic shift_step;
    logic count_dec;
    logic emit;
  } fbl_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              empty;
    logic              over;
    logic              hit;
    logic              miss;
    logic              sh_pend;
    logic              out_free;
  } fbl_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/free_block_list_first_fit.sv
// Top level of the first-fit free block list: controller plus datapath.
// Depends on fbl_pkg, fbl_ctrl, fbl_dpath.
//
//   channel | handshake           | word
//   in      | in_valid / in_stall | func, block_addr, size_value
//   out     | out_valid/out_stall | found, result_addr, result_size, total_free, list_full
//
// One word at a time. Free, rebuild and unused codes go from decode to emit, which loads the output register.
// Lookups and obtains also scan from the newest entry down; an obtain then shifts
// each entry above the taken block down by one. One entry is read per cycle.
// rst is synchronous and empties the list and the total; memory contents are not cleared.
// A new word is accepted while a finished result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module free_block_list_first_fit import fbl_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [FUNC_W-1:0]    func,
  input  wire logic [ADDR_BITS-1:0] block_addr,
  input  wire logic [SIZE_BITS-1:0] size_value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      found,
  output logic [ADDR_BITS-1:0]      result_addr,
  output logic [SIZE_BITS-1:0]      result_size,
  output logic [TOTAL_W-1:0]        total_free,
  output logic                      list_full
);

  fbl_cmd_t cmd;
  fbl_sts_t sts;

  fbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbl_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .func        (func),
    .block_addr  (block_addr),
    .size_value  (size_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .result_addr (result_addr),
    .result_size (result_size),
    .total_free  (total_free),
    .list_full   (list_full)
  );

endmodule

`default_nettype wire

>>> hw/rtl/fbl_ctrl.sv
// Controller state machine for the free block list.
// Depends on fbl_pkg; drives fbl_dpath through fbl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module fbl_ctrl import fbl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire fbl_sts_t sts,
  output fbl_cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_SHIFT  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  func_t  fn;

  assign fn       = func_t'(sts.func);
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_EMIT;
        if (fn == FN_FREE) begin
          cmd.push = 1'b1;
        end else if (fn == FN_REBLD) begin
          cmd.clear = 1'b1;
        end else if (fn inside {FN_OBT_S, FN_LKP_S}) begin
          if (!sts.empty) begin
            cmd.scan_start  = 1'b1;
            cmd.scan_single = 1'b1;
            state_next      = ST_SCAN;
          end
        end else if (fn inside {FN_OBT_L, FN_LKP_L}) begin
          if (!sts.empty && !(fn == FN_LKP_L && sts.over)) begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit) begin
          if (fn inside {FN_OBT_S, FN_OBT_L}) begin
            cmd.shift_start = 1'b1;
            state_next      = ST_SHIFT;
          end else begin
            state_next = ST_EMIT;
          end
        end else if (sts.miss) begin
          state_next = ST_EMIT;
        end
      end
      ST_SHIFT: begin
        if (sts.sh_pend) begin
          cmd.shift_step = 1'b1;
        end else begin
          cmd.count_dec = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.push, cmd.clear, cmd.scan_start, cmd.shift_step,
              cmd.count_dec, cmd.emit}))
    else $error("fbl_ctrl: conflicting commands");
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("fbl_ctrl: emit while output word held");
  a_shift_entry: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_start |-> (cmd.scan_step && sts.hit))
    else $error("fbl_ctrl: removal without a hit");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/fbl_dpath.sv
// Datapath: block memory, count, running total, scan and shift pointers, output word.
// Depends on fbl_pkg; commanded by fbl_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module fbl_dpath import fbl_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire fbl_cmd_t             cmd,
  output fbl_sts_t                  sts,
  input  wire logic [FUNC_W-1:0]    func,
  input  wire logic [ADDR_BITS-1:0] block_addr,
  input  wire logic [SIZE_BITS-1:0] size_value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      found,
  output logic [ADDR_BITS-1:0]      result_addr,
  output logic [SIZE_BITS-1:0]      result_size,
  output logic [TOTAL_W-1:0]        total_free,
  output logic                      list_full
);

  entry_t mem [LIST_DEPTH];
  entry_t rd_q;

  logic [FUNC_W-1:0]    func_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [SIZE_BITS-1:0] size_q;
  logic [CNT_W-1:0]     count;
  logic [TOTAL_W-1:0]   total;

  logic [IDX_W-1:0] scan_idx;
  logic             scan_left;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic [IDX_W-1:0] sh_wr;
  logic             sh_pend;

  logic                 res_found;
  logic [ADDR_BITS-1:0] res_addr;
  logic [SIZE_BITS-1:0] res_size;
  logic                 res_full;

  logic             hit;
  logic             full;
  logic [CNT_W-1:0] cnt_m1;
  logic             src_ok;
  logic             next_ok;
  logic             rd_en;
  logic [IDX_W-1:0] raddr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  assign hit     = pend && (rd_q.size >= size_q);
  assign full    = (count == CNT_W'(LIST_DEPTH));
  assign cnt_m1  = count - CNT_W'(1);
  assign src_ok  = (SUM_W'(pend_idx) + SUM_W'(1)) < SUM_W'(count);
  assign next_ok = (SUM_W'(sh_wr) + SUM_W'(2)) < SUM_W'(count);

  assign sts.func     = func_q;
  assign sts.empty    = (count == '0);
  assign sts.over     = total < TOTAL_W'(size_q);
  assign sts.hit      = hit;
  assign sts.miss     = pend && !hit && !scan_left;
  assign sts.sh_pend  = sh_pend;
  assign sts.out_free = !out_valid || !out_stall;

  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    if (cmd.scan_start) begin
      rd_en = 1'b1;
      raddr = cnt_m1[IDX_W-1:0];
    end else if (cmd.shift_start) begin
      rd_en = src_ok;
      raddr = pend_idx + IDX_W'(1);
    end else if (cmd.scan_step && !hit && scan_left) begin
      rd_en = 1'b1;
      raddr = scan_idx;
    end else if (cmd.shift_step) begin
      rd_en = next_ok;
      raddr = sh_wr + IDX_W'(2);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rd_q;
    if (cmd.push && !full) begin
      we    = 1'b1;
      waddr = count[IDX_W-1:0];
      wdata = '{addr: addr_q, size: size_q};
    end else if (cmd.shift_step && sh_pend) begin
      we    = 1'b1;
      waddr = sh_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q    <= func;
      addr_q    <= block_addr;
      size_q    <= size_value;
      res_found <= 1'b0;
      res_addr  <= '0;
      res_size  <= '0;
      res_full  <= 1'b0;
    end
    if (cmd.push && full) begin
      res_full <= 1'b1;
    end
    if (cmd.scan_start) begin
      pend_idx <= cnt_m1[IDX_W-1:0];
      scan_idx <= cnt_m1[IDX_W-1:0] - IDX_W'(1);
    end else if (cmd.scan_step) begin
      if (hit) begin
        res_found <= 1'b1;
        res_addr  <= rd_q.addr;
        res_size  <= rd_q.size;
      end else if (scan_left) begin
        pend_idx <= scan_idx;
        scan_idx <= scan_idx - IDX_W'(1);
      end
    end
    if (cmd.shift_start) begin
      sh_wr <= pend_idx;
    end else if (cmd.shift_step && sh_pend) begin
      sh_wr <= sh_wr + IDX_W'(1);
    end
    if (cmd.emit) begin
      found       <= res_found;
      result_addr <= res_addr;
      result_size <= res_size;
      total_free  <= total;
      list_full   <= res_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      total     <= '0;
      pend      <= 1'b0;
      scan_left <= 1'b0;
      sh_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push && !full) begin
        count <= count + CNT_W'(1);
        total <= total + TOTAL_W'(size_q);
      end else if (cmd.clear) begin
        count <= '0;
        total <= '0;
      end else if (cmd.shift_start) begin
        total <= total - TOTAL_W'(rd_q.size);
      end else if (cmd.count_dec) begin
        count <= cnt_m1;
      end
      if (cmd.scan_start) begin
        pend      <= 1'b1;
        scan_left <= !cmd.scan_single && (count > CNT_W'(1));
      end else if (cmd.scan_step && !hit) begin
        if (scan_left) begin
          scan_left <= (scan_idx != '0);
        end else begin
          pend <= 1'b0;
        end
      end
      if (cmd.shift_start) begin
        sh_pend <= src_ok;
      end else if (cmd.shift_step && sh_pend) begin
        sh_pend <= next_ok;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(LIST_DEPTH))
    else $error("fbl_dpath: count beyond list depth");
  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    sh_pend |-> ((SUM_W'(sh_wr) + SUM_W'(1)) < SUM_W'(count)))
    else $error("fbl_dpath: shift source outside list");
  a_dec_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.count_dec |-> (count != '0))
    else $error("fbl_dpath: removal from empty list");
`endif

endmodule

`default_nettype wire
